// ===== sv/tss_pkg.sv =====
// shared types, widths and constants for the triangle scanline span block
package tss_pkg;

    // vertex coordinate width
    localparam int COORD_BITS = 12;
    localparam int ROW_W      = 11;
    localparam int REG_W      = 12;
    localparam int SPAN_W     = 11;

    // arithmetic widths derived from the coordinate width
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DY_W   = ((COORD_BITS > ROW_W + 1) ? COORD_BITS : ROW_W + 1) + 1;
    localparam int P1_W   = COORD_BITS + COORD_BITS + 1;
    localparam int P2_W   = DY_W + DIFF_W;
    localparam int NUM_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
    localparam int REM_W  = NUM_W + 2;
    localparam int DV_W   = COORD_BITS + 1;
    localparam int Q_W    = COORD_BITS + 1;
    localparam int X_W    = Q_W + 1;
    localparam int DIV_LAT = Q_W + 3;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(640);
    localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(480);
    localparam logic [REG_W-1:0] MAX_SPAN   = REG_W'(2048);

    // queue sizes
    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = 2;
    localparam int OQ_DEPTH = 32;
    localparam int OQ_AW    = 5;

    // one edge to evaluate at the row
    typedef struct packed {
        logic signed [COORD_BITS-1:0] xa;
        logic signed [COORD_BITS-1:0] ya;
        logic signed [COORD_BITS-1:0] xb;
        logic signed [COORD_BITS-1:0] yb;
        logic                         hz;
        logic signed [COORD_BITS-1:0] fb;
    } t_edge;

    // classified item handed from front to back
    typedef struct packed {
        logic             miss;
        logic [ROW_W-1:0] row;
        t_edge            e1;
        t_edge            e2;
    } t_job;

    // one result
    typedef struct packed {
        logic              covered;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
    } t_res;

endpackage

// ===== sv/triangle_scanline_span.sv =====
// top level: triangle scanline span, queue interface on both sides
// path: job queue, then the edge divider stages, then the result queue (empty low)
// throughput: one item per cycle while credits last, set by the fully pipelined edge
//   dividers (one quotient bit per stage), 32-entry result queue tracked by credits
// reset: synchronous active low; empties both queues and loads width 640, height 480
module triangle_scanline_span (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_addr,
    input  logic        [tss_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_a_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_a_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_b_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_b_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_c_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_c_y,
    input  logic        [tss_pkg::ROW_W-1:0]      i_scan_row,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  o_covered,
    output logic        [tss_pkg::SPAN_W-1:0]     o_span_start,
    output logic        [tss_pkg::SPAN_W-1:0]     o_span_end
);
    logic [tss_pkg::REG_W-1:0] r_width, r_height;
    tss_pkg::t_job             job_in, job_out;
    tss_pkg::t_res             res;
    logic                      jq_empty, jq_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tss_pkg::WIDTH_RST;
            r_height <= tss_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tss_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                tss_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tss_front u_front (
        .i_vertex_a_x (i_vertex_a_x),
        .i_vertex_a_y (i_vertex_a_y),
        .i_vertex_b_x (i_vertex_b_x),
        .i_vertex_b_y (i_vertex_b_y),
        .i_vertex_c_x (i_vertex_c_x),
        .i_vertex_c_y (i_vertex_c_y),
        .i_scan_row   (i_scan_row),
        .i_height     (r_height),
        .o_job        (job_in)
    );

    tss_job_queue u_jq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_data  (job_out)
    );

    tss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jq_empty),
        .i_job       (job_out),
        .o_job_pop   (jq_pop),
        .i_width     (r_width),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    // result beat fields
    assign o_covered    = res.covered;
    assign o_span_start = res.span_start;
    assign o_span_end   = res.span_end;
endmodule

// ===== sv/tss_front.sv =====
// front end: finds the top vertex, picks each side's edge and flags rows off the triangle or at or below the height
module tss_front (
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_a_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_a_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_b_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_b_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_c_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] i_vertex_c_y,
    input  logic        [tss_pkg::ROW_W-1:0]      i_scan_row,
    input  logic        [tss_pkg::REG_W-1:0]      i_height,
    output tss_pkg::t_job                         o_job
);
    logic signed [tss_pkg::COORD_BITS-1:0] tx, ty, mx, my, nx, ny, by;
    logic signed [tss_pkg::DY_W-1:0]       row_s, ty_s, by_s, my_s, ny_s;

    // top vertex is the first lowest y, the others keep order
    always_comb begin
        if (i_vertex_c_y < i_vertex_a_y && i_vertex_c_y < i_vertex_b_y) begin
            tx = i_vertex_c_x; ty = i_vertex_c_y;
            mx = i_vertex_a_x; my = i_vertex_a_y;
            nx = i_vertex_b_x; ny = i_vertex_b_y;
        end else if (i_vertex_b_y < i_vertex_a_y) begin
            tx = i_vertex_b_x; ty = i_vertex_b_y;
            mx = i_vertex_a_x; my = i_vertex_a_y;
            nx = i_vertex_c_x; ny = i_vertex_c_y;
        end else begin
            tx = i_vertex_a_x; ty = i_vertex_a_y;
            mx = i_vertex_b_x; my = i_vertex_b_y;
            nx = i_vertex_c_x; ny = i_vertex_c_y;
        end
        by = i_vertex_a_y;
        if (i_vertex_b_y > by) by = i_vertex_b_y;
        if (i_vertex_c_y > by) by = i_vertex_c_y;
    end

    assign row_s = $signed({{(tss_pkg::DY_W-tss_pkg::ROW_W){1'b0}}, i_scan_row});
    assign ty_s  = tss_pkg::DY_W'(ty);
    assign by_s  = tss_pkg::DY_W'(by);
    assign my_s  = tss_pkg::DY_W'(my);
    assign ny_s  = tss_pkg::DY_W'(ny);

    // edge choice per side and the miss flag
    always_comb begin
        o_job.row  = i_scan_row;
        o_job.miss = (row_s < ty_s) || (row_s > by_s) ||
                     ({1'b0, i_scan_row} >= i_height);
        if (row_s >= my_s) begin
            o_job.e1.xa = mx; o_job.e1.ya = my; o_job.e1.xb = nx; o_job.e1.yb = ny;
        end else begin
            o_job.e1.xa = tx; o_job.e1.ya = ty; o_job.e1.xb = mx; o_job.e1.yb = my;
        end
        o_job.e1.hz = (o_job.e1.ya == o_job.e1.yb);
        o_job.e1.fb = mx;
        if (row_s >= ny_s) begin
            o_job.e2.xa = mx; o_job.e2.ya = my; o_job.e2.xb = nx; o_job.e2.yb = ny;
        end else begin
            o_job.e2.xa = tx; o_job.e2.ya = ty; o_job.e2.xb = nx; o_job.e2.yb = ny;
        end
        o_job.e2.hz = (o_job.e2.ya == o_job.e2.yb);
        o_job.e2.fb = nx;
    end
endmodule

// ===== sv/tss_job_queue.sv =====
// short queue of classified items between front and back
module tss_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tss_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tss_pkg::t_job o_data
);
    tss_pkg::t_job                r_mem [tss_pkg::JQ_DEPTH];
    logic [tss_pkg::JQ_AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [tss_pkg::JQ_AW:0]      r_cnt, n_cnt;
    logic                         do_push, do_pop;

    assign o_full  = (r_cnt == (tss_pkg::JQ_AW+1)'(tss_pkg::JQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (tss_pkg::JQ_AW+1)'(do_push) - (tss_pkg::JQ_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== sv/tss_edge_div.sv =====
// pipelined edge intercept: two products, sum, restoring divide with half-away rounding
module tss_edge_div (
    input  logic                               i_clk,
    input  tss_pkg::t_edge                     i_edge,
    input  logic [tss_pkg::ROW_W-1:0]          i_row,
    output logic signed [tss_pkg::X_W-1:0]     o_x
);
    localparam int CW = tss_pkg::COORD_BITS;
    localparam int QW = tss_pkg::Q_W;

    logic signed [tss_pkg::DIFF_W-1:0] den, dx, adj_dx;
    logic        [CW-1:0]              ad;
    logic signed [tss_pkg::DY_W-1:0]   dy;

    // stage 1: products
    logic signed [tss_pkg::P1_W-1:0]   r_p1;
    logic signed [tss_pkg::P2_W-1:0]   r_p2;
    logic        [CW-1:0]              r_ad1;
    logic                              r_hz1;
    logic signed [CW-1:0]              r_fb1;

    assign den    = tss_pkg::DIFF_W'(i_edge.yb) - tss_pkg::DIFF_W'(i_edge.ya);
    assign dx     = tss_pkg::DIFF_W'(i_edge.xb) - tss_pkg::DIFF_W'(i_edge.xa);
    assign ad     = den[tss_pkg::DIFF_W-1] ? CW'(-den) : CW'(den);
    assign adj_dx = den[tss_pkg::DIFF_W-1] ? -dx : dx;
    assign dy     = $signed({{(tss_pkg::DY_W-tss_pkg::ROW_W){1'b0}}, i_row})
                    - tss_pkg::DY_W'(i_edge.ya);

    always_ff @(posedge i_clk) begin
        r_p1  <= tss_pkg::P1_W'(i_edge.xa) * tss_pkg::P1_W'($signed({1'b0, ad}));
        r_p2  <= dy * adj_dx;
        r_ad1 <= ad;
        r_hz1 <= i_edge.hz;
        r_fb1 <= i_edge.fb;
    end

    // stage 2: numerator magnitude and rounded dividend
    logic signed [tss_pkg::NUM_W-1:0] num;
    logic        [tss_pkg::NUM_W-1:0] an;
    assign num = tss_pkg::NUM_W'(r_p1) + tss_pkg::NUM_W'(r_p2);
    assign an  = num[tss_pkg::NUM_W-1] ? tss_pkg::NUM_W'(-num) : tss_pkg::NUM_W'(num);

    logic [tss_pkg::REM_W-1:0] r_rem [QW+1];
    logic [tss_pkg::DV_W-1:0]  r_dv  [QW+1];
    logic [QW-1:0]             r_q   [QW+1];
    logic                      r_neg [QW+1];
    logic                      r_hz  [QW+1];
    logic signed [CW-1:0]      r_fb  [QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {an, 1'b0} + tss_pkg::REM_W'(r_ad1);
        r_dv[0]  <= {r_ad1, 1'b0};
        r_q[0]   <= '0;
        r_neg[0] <= num[tss_pkg::NUM_W-1];
        r_hz[0]  <= r_hz1;
        r_fb[0]  <= r_fb1;
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [tss_pkg::REM_W:0] trial;
        assign trial = {1'b0, r_rem[k]} -
                       ((tss_pkg::REM_W+1)'(r_dv[k]) << (QW-1-k));
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= trial[tss_pkg::REM_W] ? r_rem[k] : trial[tss_pkg::REM_W-1:0];
            r_q[k+1]   <= r_q[k] | (trial[tss_pkg::REM_W] ? '0 : (QW'(1) << (QW-1-k)));
            r_dv[k+1]  <= r_dv[k];
            r_neg[k+1] <= r_neg[k];
            r_hz[k+1]  <= r_hz[k];
            r_fb[k+1]  <= r_fb[k];
        end
    end

    // final: sign and horizontal fallback
    logic signed [tss_pkg::X_W-1:0] qs;
    assign qs = $signed({1'b0, r_q[QW]});
    always_ff @(posedge i_clk) begin
        if (r_hz[QW]) begin
            o_x <= tss_pkg::X_W'(r_fb[QW]);
        end else begin
            o_x <= r_neg[QW] ? -qs : qs;
        end
    end
endmodule

// ===== sv/tss_back.sv =====
// back end: edge pipelines, span clipping and the result queue with credit control
module tss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_empty,
    input  tss_pkg::t_job               i_job,
    output logic                        o_job_pop,
    input  logic [tss_pkg::REG_W-1:0]   i_width,
    input  logic                        i_pop,
    output logic                        o_empty,
    output tss_pkg::t_res               o_res
);
    localparam int LAT = tss_pkg::DIV_LAT;

    logic [tss_pkg::OQ_AW:0]       r_cred;
    logic                          out_pop, res_push;
    logic                          r_vld  [LAT];
    logic                          r_miss [LAT];
    logic signed [tss_pkg::X_W-1:0] x1, x2;

    // issue only while the result queue has room for everything in flight
    assign o_job_pop = !i_job_empty &&
                       (r_cred != (tss_pkg::OQ_AW+1)'(tss_pkg::OQ_DEPTH));

    tss_edge_div u_div1 (
        .i_clk  (i_clk),
        .i_edge (i_job.e1),
        .i_row  (i_job.row),
        .o_x    (x1)
    );
    tss_edge_div u_div2 (
        .i_clk  (i_clk),
        .i_edge (i_job.e2),
        .i_row  (i_job.row),
        .o_x    (x2)
    );

    // valid and miss line alongside the edge pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= o_job_pop;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_miss[0] <= i_job.miss;
        for (int i = 1; i < LAT; i++) r_miss[i] <= r_miss[i-1];
    end

    // order, clip and decide coverage
    logic signed [tss_pkg::X_W-1:0] lo, hi, lo_c, hi_c, wmax;
    tss_pkg::t_res                  res;
    always_comb begin
        lo   = (x1 < x2) ? x1 : x2;
        hi   = (x1 < x2) ? x2 : x1;
        wmax = tss_pkg::X_W'((i_width > tss_pkg::MAX_SPAN) ? tss_pkg::MAX_SPAN : i_width)
               - tss_pkg::X_W'(1);
        lo_c = (lo < 0) ? '0 : lo;
        hi_c = (hi > wmax) ? wmax : hi;
        res.covered    = !r_miss[LAT-1] && (lo_c <= hi_c);
        res.span_start = res.covered ? lo_c[tss_pkg::SPAN_W-1:0] : '0;
        res.span_end   = res.covered ? hi_c[tss_pkg::SPAN_W-1:0] : '0;
    end
    assign res_push = r_vld[LAT-1];

    // result queue
    tss_pkg::t_res              r_oq [tss_pkg::OQ_DEPTH];
    logic [tss_pkg::OQ_AW-1:0]  r_wp, r_rp;
    logic [tss_pkg::OQ_AW:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign out_pop = i_pop && !o_empty;
    assign o_res   = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_cred <= '0;
        end else begin
            if (res_push) r_wp <= r_wp + 1'b1;
            if (out_pop)  r_rp <= r_rp + 1'b1;
            r_cnt  <= r_cnt + (tss_pkg::OQ_AW+1)'(res_push) - (tss_pkg::OQ_AW+1)'(out_pop);
            r_cred <= r_cred + (tss_pkg::OQ_AW+1)'(o_job_pop) - (tss_pkg::OQ_AW+1)'(out_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_wp] <= res;
        end
    end
endmodule
